### rtl/assert_macros.svh
// Assertion macros used by the top level to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Same-cycle assertion failed.");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Next-cycle assertion failed.");

`endif

### rtl/rfns_pkg.sv
// Package with the constants and types of the four-neighbour raster sum.
package rfns_pkg;

   localparam int RFNS_VALUE_W       = 32;
   localparam int RFNS_SUM_W         = 34;
   localparam int RFNS_CFG_W         = 11;
   localparam int RFNS_MAX_COLUMNS   = 1024;
   localparam int RFNS_VALUE_BITS    = 32;
   localparam int RFNS_RESET_COLUMNS = 1024;

   typedef enum logic [1:0] {
      PHASE_FIRST,
      PHASE_SECOND,
      PHASE_LATER
   } rfns_phase_type;

   typedef struct packed {
      logic           last;
      logic           first_col;
      rfns_phase_type phase;
   } rfns_pos_type;

   typedef struct packed {
      logic           last;
      logic           first_col;
      logic           padding;
      logic           present;
      rfns_phase_type phase;
   } rfns_ctl_type;

endpackage

### rtl/rfns_req_if.sv
// Interface of the cell input channel.
interface rfns_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [rfns_pkg::RFNS_VALUE_W-1:0] cell_value;
   logic                                   cell_present;
   logic                                   frame_start;
   logic                                   padding_row;

   modport source (
      output valid, cell_value, cell_present, frame_start, padding_row,
      input  ready
   );

   modport sink (
      input  valid, cell_value, cell_present, frame_start, padding_row,
      output ready
   );
endinterface

### rtl/rfns_rsp_if.sv
// Interface of the neighbour sum result channel.
interface rfns_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [rfns_pkg::RFNS_SUM_W-1:0] neighbour_sum;
   logic                                 sum_present;
   logic                                 frame_end;

   modport source (
      output valid, neighbour_sum, sum_present, frame_end,
      input  ready
   );

   modport sink (
      input  valid, neighbour_sum, sum_present, frame_end,
      output ready
   );
endinterface

### rtl/rfns_ram.sv
// Row store memory with one write port and one registered read port.
module rfns_ram #(
   parameter int DEPTH = rfns_pkg::RFNS_MAX_COLUMNS,
   parameter int WIDTH = rfns_pkg::RFNS_VALUE_BITS + 1
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

### rtl/rfns_scan.sv
// Column counter, row phase tracking and the column count register.
module rfns_scan #(
   parameter int MAX_COLUMNS = rfns_pkg::RFNS_MAX_COLUMNS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic                              frame_start,
   input  logic                              padding,
   input  logic                              csr_we,
   input  logic [rfns_pkg::RFNS_CFG_W-1:0]   csr_wdata,
   output logic [$clog2(MAX_COLUMNS)-1:0]    col,
   output rfns_pkg::rfns_pos_type            pos
);

   localparam int COL_BITS   = $clog2(MAX_COLUMNS);
   localparam int RESET_COLS = (rfns_pkg::RFNS_RESET_COLUMNS > MAX_COLUMNS) ?
                               MAX_COLUMNS : rfns_pkg::RFNS_RESET_COLUMNS;

   logic [COL_BITS-1:0]      last_idx_ff, last_idx_in;
   logic [COL_BITS-1:0]      count_ff, count_in;
   logic [COL_BITS-1:0]      base;
   rfns_pkg::rfns_phase_type phase_ff, phase_in, phase_cur;
   logic                     last;

   // The register holds the index of the last column, clamped to the store depth.
   always_comb begin
      if (csr_wdata == '0) begin
         last_idx_in = '0;
      end else if (32'(csr_wdata) > MAX_COLUMNS) begin
         last_idx_in = COL_BITS'(MAX_COLUMNS - 1);
      end else begin
         last_idx_in = COL_BITS'(csr_wdata - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_idx_ff <= COL_BITS'(RESET_COLS - 1);
      end else if (csr_we) begin
         last_idx_ff <= last_idx_in;
      end
   end

   always_comb begin
      base      = frame_start ? '0 : count_ff;
      phase_cur = frame_start ? rfns_pkg::PHASE_FIRST : phase_ff;
      col       = (base > last_idx_ff) ? last_idx_ff : base;
      last      = (col == last_idx_ff);
      if (last) begin
         count_in = '0;
         if (padding) begin
            phase_in = rfns_pkg::PHASE_FIRST;
         end else begin
            case (phase_cur)
               rfns_pkg::PHASE_FIRST: phase_in = rfns_pkg::PHASE_SECOND;
               default:               phase_in = rfns_pkg::PHASE_LATER;
            endcase
         end
      end else begin
         count_in = COL_BITS'(col + 1'b1);
         phase_in = phase_cur;
      end
      pos.last      = last;
      pos.first_col = (col == '0);
      pos.phase     = phase_cur;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         phase_ff <= rfns_pkg::PHASE_FIRST;
      end else if (accept) begin
         count_ff <= count_in;
         phase_ff <= phase_in;
      end
   end

endmodule

### rtl/rfns_window.sv
// Neighbour window over the previous row, the sum and the result register.
module rfns_window #(
   parameter int VALUE_BITS = rfns_pkg::RFNS_VALUE_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   s1_valid,
   input  rfns_pkg::rfns_ctl_type ctl,
   input  logic [VALUE_BITS-1:0]  value,
   input  logic [VALUE_BITS:0]    centre_q,
   input  logic [VALUE_BITS:0]    centre0,
   input  logic [VALUE_BITS:0]    above_q,
   output logic                   advance,
   output logic [VALUE_BITS:0]    above_wdata,
   rfns_rsp_if.source             rsp
);

   localparam int SUM_W    = rfns_pkg::RFNS_SUM_W;
   localparam int CELL_W   = VALUE_BITS + 1;
   localparam int EXT_BITS = (VALUE_BITS > SUM_W) ? VALUE_BITS : SUM_W;

   logic [CELL_W-1:0] win_ff [3];
   logic [CELL_W-1:0] win_in [3];
   logic [CELL_W-1:0] own;
   logic [SUM_W-1:0]  sum;
   logic              any;
   logic              use_above;
   logic              produce;
   logic              rsp_valid_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic              present_ff;
   logic              end_ff;

   function automatic logic [SUM_W-1:0] term(input logic [CELL_W-1:0] entry,
                                             input logic en);
      logic [EXT_BITS-1:0] wide;
      wide = EXT_BITS'(signed'(entry[VALUE_BITS-1:0]));
      return (en && entry[VALUE_BITS]) ? wide[SUM_W-1:0] : '0;
   endfunction

   // At the first column the window is reloaded; otherwise it slides by one.
   always_comb begin
      win_in[0]   = ctl.first_col ? '0 : win_ff[1];
      win_in[1]   = ctl.first_col ? centre0 : win_ff[2];
      win_in[2]   = ctl.last ? '0 : centre_q;
      above_wdata = win_in[1];
      own         = {ctl.present, value};
      use_above   = (ctl.phase == rfns_pkg::PHASE_LATER);
      produce     = (ctl.phase != rfns_pkg::PHASE_FIRST);
      sum         = term(above_q, use_above) + term(win_in[0], 1'b1) +
                    term(win_in[2], 1'b1) + term(own, 1'b1);
      any         = (use_above && above_q[VALUE_BITS]) || win_in[0][VALUE_BITS] ||
                    win_in[2][VALUE_BITS] || ctl.present;
      advance     = s1_valid && (!produce || !rsp_valid_ff || rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff[0] <= '0;
         win_ff[1] <= '0;
         win_ff[2] <= '0;
      end else if (advance) begin
         win_ff[0] <= win_in[0];
         win_ff[1] <= win_in[1];
         win_ff[2] <= win_in[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && produce) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && produce) begin
         sum_ff     <= sum;
         present_ff <= any;
         end_ff     <= ctl.padding && ctl.last;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.neighbour_sum = $signed(sum_ff);
   assign rsp.sum_present   = present_ff;
   assign rsp.frame_end     = end_ff;

endmodule

### rtl/raster_four_neighbour_sum.sv
// Top level of the streamed four-neighbour raster sum with missing values.
//
//  Channel    Direction  Handshake         Carries
//  req_chan   in         valid / ready     cell_value, cell_present, frame_start, padding_row
//  rsp_chan   out        valid / ready     neighbour_sum, sum_present, frame_end
//  csr        in         csr_we            csr_wdata: columns in use
//
// One transaction is accepted per cycle while the window stage does not stall. A cell passes
// through the stage registers and the registered read ports of the two row stores, which feed
// the window and adder stage in the cycle after acceptance; its result is then registered.
// Reset is synchronous and clears the counters, the window and the result valid.
// A stalled result holds the window stage, which in turn holds the input ready low.
module raster_four_neighbour_sum #(
   parameter int MAX_COLUMNS = rfns_pkg::RFNS_MAX_COLUMNS,
   parameter int VALUE_BITS  = rfns_pkg::RFNS_VALUE_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   rfns_req_if.sink                        req_chan,
   rfns_rsp_if.source                      rsp_chan,
   input  logic                            csr_we,
   input  logic [rfns_pkg::RFNS_CFG_W-1:0] csr_wdata
);

   `include "assert_macros.svh"

   localparam int COL_BITS = $clog2(MAX_COLUMNS);
   localparam int CELL_W   = VALUE_BITS + 1;
   localparam int IN_EXT   = (VALUE_BITS > rfns_pkg::RFNS_VALUE_W) ?
                             VALUE_BITS : rfns_pkg::RFNS_VALUE_W;

   logic                   accept;
   logic                   advance;
   logic [IN_EXT-1:0]      in_wide;
   logic [VALUE_BITS-1:0]  in_value;
   logic                   in_present;
   logic [COL_BITS-1:0]    col;
   rfns_pkg::rfns_pos_type pos;
   logic [COL_BITS-1:0]    centre_raddr;
   logic [CELL_W-1:0]      centre_wdata;
   logic [CELL_W-1:0]      centre_rdata;
   logic [CELL_W-1:0]      above_rdata;
   logic [CELL_W-1:0]      above_q;
   logic [CELL_W-1:0]      above_wdata;

   logic                   s1_valid_ff;
   rfns_pkg::rfns_ctl_type s1_ctl_ff;
   logic [COL_BITS-1:0]    s1_col_ff;
   logic [VALUE_BITS-1:0]  s1_value_ff;
   logic [CELL_W-1:0]      s1_c0_ff;
   logic [CELL_W-1:0]      c0_ff;
   logic                   byp_hit_ff;
   logic [CELL_W-1:0]      byp_data_ff;

   assign accept     = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !s1_valid_ff || advance;
   assign in_wide    = IN_EXT'($unsigned(req_chan.cell_value));
   assign in_value   = in_wide[VALUE_BITS-1:0];
   assign in_present = req_chan.cell_present && !req_chan.padding_row;

   rfns_scan #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .frame_start (req_chan.frame_start),
      .padding     (req_chan.padding_row),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .col         (col),
      .pos         (pos)
   );

   // Column zero of the previous row is kept in a register so that the first
   // column can reload both of its window places in one pass.
   assign centre_wdata = {in_present, in_value};
   assign centre_raddr = pos.first_col ? COL_BITS'(1) : COL_BITS'(col + 1'b1);

   rfns_ram #(
      .DEPTH (MAX_COLUMNS),
      .WIDTH (CELL_W)
   ) u_centre_store (
      .clock (clock),
      .we    (accept),
      .waddr (col),
      .wdata (centre_wdata),
      .re    (accept),
      .raddr (centre_raddr),
      .rdata (centre_rdata)
   );

   rfns_ram #(
      .DEPTH (MAX_COLUMNS),
      .WIDTH (CELL_W)
   ) u_above_store (
      .clock (clock),
      .we    (advance),
      .waddr (s1_col_ff),
      .wdata (above_wdata),
      .re    (accept),
      .raddr (col),
      .rdata (above_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // The above store is written as the window stage retires a transaction, so a
   // read of that column in the same cycle takes the write data instead.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ctl_ff.last      <= pos.last;
         s1_ctl_ff.first_col <= pos.first_col;
         s1_ctl_ff.phase     <= pos.phase;
         s1_ctl_ff.padding   <= req_chan.padding_row;
         s1_ctl_ff.present   <= in_present;
         s1_col_ff           <= col;
         s1_value_ff         <= in_value;
         s1_c0_ff            <= c0_ff;
         byp_hit_ff          <= advance && (s1_col_ff == col);
         byp_data_ff         <= above_wdata;
      end
      if (accept && pos.first_col) begin
         c0_ff <= centre_wdata;
      end
   end

   assign above_q = byp_hit_ff ? byp_data_ff : above_rdata;

   rfns_window #(
      .VALUE_BITS (VALUE_BITS)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .s1_valid    (s1_valid_ff),
      .ctl         (s1_ctl_ff),
      .value       (s1_value_ff),
      .centre_q    (centre_rdata),
      .centre0     (s1_c0_ff),
      .above_q     (above_q),
      .advance     (advance),
      .above_wdata (above_wdata),
      .rsp         (rsp_chan)
   );

   `ASSERT_NEXT_CYCLE(a_accept_fills_stage, clock, reset, accept, s1_valid_ff)
   `ASSERT_SAME_CYCLE(a_stall_blocks_input, clock, reset, s1_valid_ff && !advance, !req_chan.ready)
   `ASSERT_SAME_CYCLE(a_first_col_is_zero, clock, reset, s1_valid_ff && s1_ctl_ff.first_col, s1_col_ff == '0)
   `ASSERT_NEXT_CYCLE(a_result_follows, clock, reset, advance && (s1_ctl_ff.phase != rfns_pkg::PHASE_FIRST), rsp_chan.valid)

endmodule

### tb/neighbour_sum_checker.sv
// Checker that predicts the four-neighbour sums of the raster stream and compares the results.
module neighbour_sum_checker (
   input  logic                            clock,
   input  logic                            reset,
   rfns_req_if                             req_mon,
   rfns_rsp_if                             rsp_mon,
   input  logic                            csr_we,
   input  logic [rfns_pkg::RFNS_CFG_W-1:0] csr_wdata,
   output int                              pending_sums,
   output int                              failures,
   output int                              sums_checked,
   output int                              frame_ends
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VALUE_W     = rfns_pkg::RFNS_VALUE_W;
   localparam int SUM_W       = rfns_pkg::RFNS_SUM_W;
   localparam int CFG_W       = rfns_pkg::RFNS_CFG_W;
   localparam int MAX_COLUMNS = rfns_pkg::RFNS_MAX_COLUMNS;

   typedef struct {
      logic signed [VALUE_W-1:0] value;
      logic                      present;
   } raster_cell;

   typedef struct {
      logic signed [SUM_W-1:0] sum;
      logic                    present;
      logic                    frame_end;
   } neighbour_result;

   raster_cell               above_row [MAX_COLUMNS];
   raster_cell               centre_row [MAX_COLUMNS];
   raster_cell               window [3];
   int                       column;
   rfns_pkg::rfns_phase_type phase;
   logic [CFG_W-1:0]         columns_setting;
   neighbour_result          expected_sums [$];

   function automatic logic signed [SUM_W-1:0] widen(
      input logic signed [VALUE_W-1:0] value
   );
      return {{(SUM_W - VALUE_W){value[VALUE_W-1]}}, value};
   endfunction

   task automatic predict_neighbour_sum(input logic signed [VALUE_W-1:0] value,
                                        input logic present, input logic start,
                                        input logic padding);
      raster_cell      gap_cell;
      neighbour_result expected;
      int              row_len;
      int              c;
      logic            last;
      gap_cell = '{value: '0, present: 1'b0};
      if (start) begin
         column = 0;
         phase  = rfns_pkg::PHASE_FIRST;
      end
      row_len = (columns_setting == 0) ? 1 :
                (columns_setting > MAX_COLUMNS) ? MAX_COLUMNS : int'(columns_setting);
      c    = (column >= row_len) ? row_len - 1 : column;
      last = (c == row_len - 1);

      // The window over the previous row is read before this column is overwritten.
      if (c == 0) begin
         window[0] = gap_cell;
         window[1] = centre_row[0];
      end else begin
         window[0] = window[1];
         window[1] = window[2];
      end
      window[2] = (c + 1 < row_len) ? centre_row[c + 1] : gap_cell;

      if (phase != rfns_pkg::PHASE_FIRST) begin
         expected = '{sum: '0, present: 1'b0, frame_end: padding && last};
         if (phase == rfns_pkg::PHASE_LATER && above_row[c].present) begin
            expected.sum     += widen(above_row[c].value);
            expected.present  = 1'b1;
         end
         if (window[0].present) begin
            expected.sum     += widen(window[0].value);
            expected.present  = 1'b1;
         end
         if (window[2].present) begin
            expected.sum     += widen(window[2].value);
            expected.present  = 1'b1;
         end
         if (!padding && present) begin
            expected.sum     += widen(value);
            expected.present  = 1'b1;
         end
         expected_sums.push_back(expected);
      end

      above_row[c]  = window[1];
      centre_row[c] = '{value: value, present: present && !padding};
      if (last) begin
         column = 0;
         if (padding) begin
            phase = rfns_pkg::PHASE_FIRST;
         end else if (phase == rfns_pkg::PHASE_FIRST) begin
            phase = rfns_pkg::PHASE_SECOND;
         end else begin
            phase = rfns_pkg::PHASE_LATER;
         end
      end else begin
         column = c + 1;
      end
   endtask

   task automatic check_neighbour_sum();
      neighbour_result expected;
      if (expected_sums.size() == 0) begin
         failures++;
         $display("%0t: unexpected result, expected none, actual sum %0d present %0b end %0b",
                  $time, rsp_mon.neighbour_sum, rsp_mon.sum_present, rsp_mon.frame_end);
      end else begin
         expected = expected_sums.pop_front();
         sums_checked++;
         if (expected.frame_end) begin
            frame_ends++;
         end
         if (rsp_mon.neighbour_sum !== expected.sum) begin
            failures++;
            $display("%0t: neighbour_sum mismatch, expected %0d, actual %0d",
                     $time, expected.sum, rsp_mon.neighbour_sum);
         end
         if (rsp_mon.sum_present !== expected.present) begin
            failures++;
            $display("%0t: sum_present mismatch, expected %0b, actual %0b",
                     $time, expected.present, rsp_mon.sum_present);
         end
         if (rsp_mon.frame_end !== expected.frame_end) begin
            failures++;
            $display("%0t: frame_end mismatch, expected %0b, actual %0b",
                     $time, expected.frame_end, rsp_mon.frame_end);
         end
      end
   endtask

   initial begin
      pending_sums = 0;
      failures     = 0;
      sums_checked = 0;
      frame_ends   = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_COLUMNS; i++) begin
            above_row[i]  = '{value: '0, present: 1'b0};
            centre_row[i] = '{value: '0, present: 1'b0};
         end
         for (int i = 0; i < 3; i++) begin
            window[i] = '{value: '0, present: 1'b0};
         end
         column          = 0;
         phase           = rfns_pkg::PHASE_FIRST;
         columns_setting = CFG_W'(rfns_pkg::RFNS_RESET_COLUMNS);
         expected_sums.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            check_neighbour_sum();
         end
         if (csr_we) begin
            columns_setting = csr_wdata;
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_neighbour_sum(req_mon.cell_value, req_mon.cell_present,
                                  req_mon.frame_start, req_mon.padding_row);
         end
      end
      pending_sums = expected_sums.size();
   end
endmodule

### tb/tb.sv
// Testbench top: clock, reset, raster cell stimulus, result acceptance and the verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VALUE_W       = rfns_pkg::RFNS_VALUE_W;
   localparam int CFG_W         = rfns_pkg::RFNS_CFG_W;
   localparam int MAX_COLUMNS   = rfns_pkg::RFNS_MAX_COLUMNS;
   localparam int CYCLE_LIMIT   = 500_000;
   localparam int SETTLE_CYCLES = 4;
   localparam int RANDOM_CELLS  = 800;
   localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;
   localparam logic [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [CFG_W-1:0] csr_wdata;
   int               pending_sums;
   int               failures;
   int               sums_checked;
   int               frame_ends;
   int               cycle_count;
   int               cells_sent;
   int               settings_used;
   int               row_len;
   bit               send_idle;
   bit               ack_idle;

   rfns_req_if req_chan ();
   rfns_rsp_if rsp_chan ();

   raster_four_neighbour_sum DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   neighbour_sum_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_chan),
      .rsp_mon      (rsp_chan),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .pending_sums (pending_sums),
      .failures     (failures),
      .sums_checked (sums_checked),
      .frame_ends   (frame_ends)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [VALUE_W-1:0] random_value();
      case ($urandom_range(0, 7))
         0: return VALUE_MAX;
         1: return VALUE_MIN;
         2: return '0;
         3: return '1;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic random_present();
      return $urandom_range(0, 3) != 0;
   endfunction

   function automatic logic [CFG_W-1:0] pick_columns();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 11'd1;
         2: return 11'd2;
         default: return CFG_W'($urandom_range(3, 12));
      endcase
   endfunction

   task automatic put_cell(input logic [VALUE_W-1:0] value, input logic present,
                           input logic start, input logic padding);
      int gap;
      gap = send_idle ? $urandom_range(0, 10) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.cell_value   <= value;
      req_chan.cell_present <= present;
      req_chan.frame_start  <= start;
      req_chan.padding_row  <= padding;
      do @(posedge clock); while (!req_chan.ready);
      cells_sent++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      wait (pending_sums == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_columns(input logic [CFG_W-1:0] setting);
      drain_results();
      csr_we    <= 1'b1;
      csr_wdata <= setting;
      @(negedge clock);
      csr_we <= 1'b0;
      row_len = (setting == 0) ? 1 :
                (setting > MAX_COLUMNS) ? MAX_COLUMNS : int'(setting);
      settings_used++;
   endtask

   task automatic send_raster(input int rows);
      for (int r = 0; r < rows; r++) begin
         for (int c = 0; c < row_len; c++) begin
            put_cell(random_value(), random_present(), r == 0 && c == 0, 1'b0);
         end
      end
      for (int c = 0; c < row_len; c++) begin
         put_cell(random_value(), random_present(), 1'b0, 1'b1);
      end
   endtask

   task automatic send_noise();
      int count;
      count = $urandom_range(4, 24);
      for (int i = 0; i < count; i++) begin
         put_cell(random_value(), random_present(), i == 0 || $urandom_range(0, 7) == 0,
                  $urandom_range(0, 3) == 0);
      end
   endtask

   initial begin
      int gap;
      rsp_chan.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         gap = ack_idle ? $urandom_range(0, 10) : 0;
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
         @(negedge clock);
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin
      int random_start;
      req_chan.valid        = 1'b0;
      req_chan.cell_value   = '0;
      req_chan.cell_present = 1'b0;
      req_chan.frame_start  = 1'b0;
      req_chan.padding_row  = 1'b0;
      csr_we                = 1'b0;
      csr_wdata             = '0;
      cells_sent            = 0;
      settings_used         = 0;
      row_len               = rfns_pkg::RFNS_RESET_COLUMNS;
      send_idle             = 1'b1;
      ack_idle              = 1'b1;
      reset                 = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Extreme values, with padding cells whose values and flags must be ignored.
      write_columns(11'd3);
      put_cell(VALUE_MAX, 1'b1, 1'b1, 1'b0);
      put_cell(VALUE_MIN, 1'b1, 1'b0, 1'b0);
      put_cell(VALUE_MAX, 1'b1, 1'b0, 1'b0);
      put_cell(VALUE_MIN, 1'b1, 1'b0, 1'b0);
      put_cell('0, 1'b0, 1'b0, 1'b0);
      put_cell('1, 1'b1, 1'b0, 1'b0);
      repeat (3) put_cell(VALUE_MAX, 1'b1, 1'b0, 1'b0);
      repeat (3) put_cell(VALUE_MIN, 1'b1, 1'b0, 1'b1);

      // A padding cell in the first row, then a restart in mid-row with every cell missing.
      put_cell(VALUE_MAX, 1'b1, 1'b1, 1'b1);
      put_cell(VALUE_MAX, 1'b0, 1'b1, 1'b0);
      put_cell(VALUE_MIN, 1'b0, 1'b0, 1'b0);
      put_cell(VALUE_MAX, 1'b0, 1'b0, 1'b0);
      repeat (3) put_cell(VALUE_MAX, 1'b1, 1'b0, 1'b1);

      // The row is shortened while the column counter sits beyond the new end.
      write_columns(11'd4);
      for (int c = 0; c < 4; c++) begin
         put_cell(random_value(), 1'b1, c == 0, 1'b0);
      end
      repeat (2) put_cell(random_value(), 1'b1, 1'b0, 1'b0);
      write_columns(11'd1);
      put_cell(VALUE_MIN, 1'b1, 1'b0, 1'b0);
      put_cell(VALUE_MAX, 1'b1, 1'b0, 1'b1);

      write_columns('1);
      send_noise();

      write_columns(pick_columns());
      random_start = cells_sent;
      while (cells_sent - random_start < RANDOM_CELLS) begin
         if ($urandom_range(0, 3) == 0) begin
            write_columns(pick_columns());
         end
         send_idle = $urandom_range(0, 3) != 0;
         ack_idle  = $urandom_range(0, 3) != 0;
         if ($urandom_range(0, 4) == 0) begin
            send_noise();
         end else begin
            send_raster($urandom_range(1, 5));
         end
         if ($urandom_range(0, 5) == 0) begin
            drain_results();
         end
      end

      drain_results();
      repeat (8) @(negedge clock);
      $display("Streamed %0d cells under %0d column settings.", cells_sent, settings_used);
      $display("Compared %0d neighbour sums, %0d of them closing a raster.",
               sums_checked, frame_ends);
      if (failures == 0 && pending_sums == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
